// ===== src/uart_brq_pkg.sv =====
// ----------------------------------------------------------------------------
// UART buffered queues package
// Shared types and constants of the UART receive and transmit queue block.
// ----------------------------------------------------------------------------
package uart_brq_pkg;

    localparam int DEFAULT_DEPTH = 32;

    typedef enum logic [1:0] {
        FUNC_LINE  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_SEND  = 2'd2,
        FUNC_READY = 2'd3
    } t_func;

    localparam logic [3:0] FLAG_OVERFLOW = 4'b1000;

    typedef struct packed {
        t_func       func;
        logic [7:0]  line_byte;
        logic [2:0]  line_flags;
        logic [7:0]  send_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_value;
        logic        no_data;
        logic [3:0]  read_flags;
        logic        send_taken;
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        tx_request;
    } t_out_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_ring_status;

endpackage

// ===== src/uart_brq_ring.sv =====
// ----------------------------------------------------------------------------
// UART buffered queues ring buffer
// One ring buffer of DEPTH slots with one slot kept empty, a synchronous
// store and a registered read of the slot after the read pointer.
// ----------------------------------------------------------------------------
module uart_brq_ring #(
    parameter int DEPTH = uart_brq_pkg::DEFAULT_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [7:0]                i_wdata,
    input  logic                      i_pop,
    output uart_brq_pkg::t_ring_status o_status,
    output logic [7:0]                o_rdata
);
    import uart_brq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [7:0]       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;

    always_comb begin
        n_wptr = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
        n_rptr = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
        o_status.full  = (n_wptr == r_rptr);
        o_status.empty = (r_wptr == r_rptr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (i_pop) begin
                r_rptr <= n_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[n_wptr] <= i_wdata;
        end
        if (i_pop) begin
            o_rdata <= r_mem[n_rptr];
        end
    end

endmodule

// ===== src/uart_buffered_rx_tx_queues_unit.sv =====
// ----------------------------------------------------------------------------
// UART buffered receive and transmit queues
// Receive and transmit ring buffers with sticky line error flags.
// ----------------------------------------------------------------------------
// An item is accepted at each rising edge with start high and busy low; busy
// stays low, so an item may be given in every cycle. Each item names one
// event: a received line byte, a software read, a software send or a
// transmitter-ready event. Its result appears on o_result in the cycle after
// acceptance, marked by o_strobe for exactly one cycle, so the throughput is one
// item per cycle. The result is registered, and the queue bytes come from the
// registered read port of the queue store. The receiver cannot stall the
// block and must take each result in the cycle it is shown. Each queue holds
// at most DEPTH-1 bytes. A synchronous reset empties both queues and clears
// the sticky flags and the transmit request; store contents are not cleared
// and need not be, since only occupied slots are ever read.
// ----------------------------------------------------------------------------
module uart_buffered_rx_tx_queues_unit #(
    parameter int DEPTH = uart_brq_pkg::DEFAULT_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  uart_brq_pkg::t_in_item  i_item,
    output logic                    o_strobe,
    output uart_brq_pkg::t_out_item o_result
);
    import uart_brq_pkg::*;

    t_ring_status rx_status;
    t_ring_status tx_status;
    logic [7:0]   rx_rdata;
    logic [7:0]   tx_rdata;
    logic         accept;
    logic         rx_push;
    logic         rx_pop;
    logic         tx_push;
    logic         tx_pop;

    logic [3:0] r_sticky;
    logic [3:0] n_sticky;
    logic       r_tx_enable;
    logic       n_tx_enable;
    logic       r_strobe;
    logic       r_read_ok;
    logic       r_no_data;
    logic [3:0] r_read_flags;
    logic       r_send_taken;
    logic       r_out_valid;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        rx_push     = accept && (i_item.func == FUNC_LINE) && !rx_status.full;
        rx_pop      = accept && (i_item.func == FUNC_READ) && !rx_status.empty;
        tx_push     = accept && (i_item.func == FUNC_SEND) && !tx_status.full;
        tx_pop      = accept && (i_item.func == FUNC_READY) && !tx_status.empty;
        n_sticky    = r_sticky;
        n_tx_enable = r_tx_enable;
        if (accept) begin
            case (i_item.func)
                FUNC_LINE: begin
                    n_sticky = r_sticky | (rx_status.full ? FLAG_OVERFLOW
                                                          : {1'b0, i_item.line_flags});
                end
                FUNC_READ: begin
                    if (!rx_status.empty) begin
                        n_sticky = '0;
                    end
                end
                FUNC_SEND: begin
                    if (!tx_status.full) begin
                        n_tx_enable = 1'b1;
                    end
                end
                FUNC_READY: begin
                    if (tx_status.empty) begin
                        n_tx_enable = 1'b0;
                    end
                end
                default: begin
                    n_sticky = r_sticky;
                end
            endcase
        end
    end

    uart_brq_ring #(
        .DEPTH (DEPTH)
    ) u_rx_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (rx_push),
        .i_wdata  (i_item.line_byte),
        .i_pop    (rx_pop),
        .o_status (rx_status),
        .o_rdata  (rx_rdata)
    );

    uart_brq_ring #(
        .DEPTH (DEPTH)
    ) u_tx_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (tx_push),
        .i_wdata  (i_item.send_value),
        .i_pop    (tx_pop),
        .o_status (tx_status),
        .o_rdata  (tx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sticky    <= '0;
            r_tx_enable <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_sticky    <= n_sticky;
            r_tx_enable <= n_tx_enable;
            r_strobe    <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_ok    <= rx_pop;
        r_no_data    <= (i_item.func == FUNC_READ) && rx_status.empty;
        r_read_flags <= rx_pop ? r_sticky : 4'd0;
        r_send_taken <= tx_push;
        r_out_valid  <= tx_pop;
    end

    always_comb begin
        o_strobe            = r_strobe;
        o_result.read_value = r_read_ok ? rx_rdata : 8'd0;
        o_result.no_data    = r_no_data;
        o_result.read_flags = r_read_flags;
        o_result.send_taken = r_send_taken;
        o_result.out_valid  = r_out_valid;
        o_result.out_byte   = r_out_valid ? tx_rdata : 8'd0;
        o_result.tx_request = r_tx_enable;
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UART buffered queues testbench
// Drives receive, read, send and transmitter-ready items into the queue block
// under several sender idle rates. A local model of both ring buffers, the
// sticky flags and the transmit request predicts every result, and each
// result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import uart_brq_pkg::*;

    localparam int QDEPTH       = DEFAULT_DEPTH;
    localparam int PW           = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int NUM_PHASES   = 4;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_in_item  i_item  = '0;
    logic      o_strobe;
    t_out_item o_result;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    logic      item_taken   = 1'b0;
    int        idle_pct     = 0;
    int        fail_count   = 0;
    int        quiet_cycles = 0;

    logic [7:0]    rx_mem [QDEPTH];
    logic [7:0]    tx_mem [QDEPTH];
    logic [PW-1:0] rx_wr = '0;
    logic [PW-1:0] rx_rd = '0;
    logic [PW-1:0] tx_wr = '0;
    logic [PW-1:0] tx_rd = '0;
    logic [3:0]    sticky = '0;
    logic          tx_en  = 1'b0;

    uart_buffered_rx_tx_queues_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [PW-1:0] ring_next(logic [PW-1:0] p);
        return (p == PW'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic t_out_item predict_event(t_in_item it);
        t_out_item     r;
        logic [PW-1:0] nxt;
        r = '0;
        case (it.func)
            FUNC_LINE: begin
                nxt = ring_next(rx_wr);
                if (nxt == rx_rd) begin
                    sticky = sticky | FLAG_OVERFLOW;
                end else begin
                    rx_mem[nxt] = it.line_byte;
                    rx_wr       = nxt;
                    sticky      = sticky | {1'b0, it.line_flags};
                end
            end
            FUNC_READ: begin
                if (rx_wr == rx_rd) begin
                    r.no_data = 1'b1;
                end else begin
                    rx_rd        = ring_next(rx_rd);
                    r.read_value = rx_mem[rx_rd];
                    r.read_flags = sticky;
                    sticky       = '0;
                end
            end
            FUNC_SEND: begin
                nxt = ring_next(tx_wr);
                if (nxt != tx_rd) begin
                    tx_mem[nxt]  = it.send_value;
                    tx_wr        = nxt;
                    tx_en        = 1'b1;
                    r.send_taken = 1'b1;
                end
            end
            default: begin
                if (tx_wr != tx_rd) begin
                    tx_rd       = ring_next(tx_rd);
                    r.out_byte  = tx_mem[tx_rd];
                    r.out_valid = 1'b1;
                end else begin
                    tx_en = 1'b0;
                end
            end
        endcase
        r.tx_request = tx_en;
        return r;
    endfunction

    function automatic t_in_item make_item(t_func f, logic [7:0] lb, logic [2:0] lf,
                                           logic [7:0] sv);
        t_in_item it;
        it.func       = f;
        it.line_byte  = lb;
        it.line_flags = lf;
        it.send_value = sv;
        return it;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || item_taken) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                start  <= 1'b1;
                i_item <= pending_items.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            item_taken   <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (o_strobe === 1'b1) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_value", o_result.read_value, want.read_value);
                    check_field("no_data", 8'(o_result.no_data), 8'(want.no_data));
                    check_field("read_flags", 8'(o_result.read_flags),
                                8'(want.read_flags));
                    check_field("send_taken", 8'(o_result.send_taken),
                                8'(want.send_taken));
                    check_field("out_valid", 8'(o_result.out_valid), 8'(want.out_valid));
                    check_field("out_byte", o_result.out_byte, want.out_byte);
                    check_field("tx_request", 8'(o_result.tx_request),
                                8'(want.tx_request));
                end
            end
            if (start && !busy) begin
                expected_results.push_back(predict_event(i_item));
            end
            item_taken <= start && !busy;
            if ((start && !busy) || o_strobe === 1'b1) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        t_in_item it;
        t_func    lead;
        int       phase;
        int       n;
        int       k;
        int       burst_len;
        int       phase_idle [NUM_PHASES];
        phase_idle = '{0, 72, 0, 25};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        pending_items.push_back(make_item(FUNC_READ, 8'h00, 3'd0, 8'h00));
        pending_items.push_back(make_item(FUNC_READY, 8'h00, 3'd0, 8'h00));
        pending_items.push_back(make_item(FUNC_LINE, 8'h00, 3'd0, 8'hFF));
        pending_items.push_back(make_item(FUNC_LINE, 8'hFF, 3'd7, 8'h00));
        pending_items.push_back(make_item(FUNC_LINE, 8'hA5, 3'd1, 8'h5A));
        pending_items.push_back(make_item(FUNC_READ, 8'hFF, 3'd7, 8'hFF));
        pending_items.push_back(make_item(FUNC_READ, 8'h00, 3'd0, 8'h00));
        pending_items.push_back(make_item(FUNC_LINE, 8'h3C, 3'd2, 8'h00));
        pending_items.push_back(make_item(FUNC_LINE, 8'hC3, 3'd4, 8'h00));
        pending_items.push_back(make_item(FUNC_READ, 8'h00, 3'd0, 8'h00));
        pending_items.push_back(make_item(FUNC_READ, 8'h00, 3'd0, 8'h00));
        pending_items.push_back(make_item(FUNC_READ, 8'h00, 3'd0, 8'h00));
        pending_items.push_back(make_item(FUNC_READ, 8'h00, 3'd0, 8'h00));
        pending_items.push_back(make_item(FUNC_SEND, 8'hFF, 3'd7, 8'h00));
        pending_items.push_back(make_item(FUNC_SEND, 8'h00, 3'd0, 8'hFF));
        pending_items.push_back(make_item(FUNC_READY, 8'h00, 3'd0, 8'h00));
        pending_items.push_back(make_item(FUNC_READY, 8'h00, 3'd0, 8'h00));
        pending_items.push_back(make_item(FUNC_READY, 8'h00, 3'd0, 8'h00));
        pending_items.push_back(make_item(FUNC_READY, 8'h00, 3'd0, 8'h00));
        pending_items.push_back(make_item(FUNC_SEND, 8'h00, 3'd0, 8'h81));
        pending_items.push_back(make_item(FUNC_READY, 8'h00, 3'd0, 8'h00));

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            idle_pct = phase_idle[phase];
            n = 0;
            while (n < RANDOM_ITEMS / NUM_PHASES) begin
                lead      = t_func'($urandom_range(0, 3));
                burst_len = $urandom_range(1, 48);
                for (k = 0; k < burst_len; k++) begin
                    if ($urandom_range(0, 99) < 80) begin
                        it.func = lead;
                    end else begin
                        it.func = t_func'($urandom_range(0, 3));
                    end
                    it.line_byte  = 8'($urandom_range(0, 255));
                    it.line_flags = 3'($urandom_range(0, 7));
                    it.send_value = 8'($urandom_range(0, 255));
                    pending_items.push_back(it);
                    n++;
                end
            end
            while (pending_items.size() != 0 || start || expected_results.size() != 0) begin
                @(posedge i_clk);
            end
        end

        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/uart_brq_pkg.sv
src/uart_brq_ring.sv
src/uart_buffered_rx_tx_queues_unit.sv
verif/testbench.sv
